// ----- rtl/core/skvlt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvlt_pkg
// Shared types and defaults for the sorted key/value leaf table.
// ----------------------------------------------------------------------------
package skvlt_pkg;

  // default sizes
  localparam int CAPACITY_DEF   = 256;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 64;

  // fixed field widths
  localparam int ACTION_W  = 3;
  localparam int STATUS_W  = 3;
  localparam int POS_IN_W  = 8;
  localparam int POS_OUT_W = 9;
  localparam int COUNT_W   = 9;
  localparam int CFG_W     = 9;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 9'd256;

  // request actions
  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_LOWER  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE7 = 3'd7;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

  // what a cell does with its entry at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_SHIFT_UP   = 2'd2,
    CELL_SHIFT_DOWN = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     cmp_en;
    logic     live;
  } cell_ctrl_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flag_t;

endpackage

// ----- rtl/core/sorted_key_value_leaf_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_value_leaf_table
// Sorted table of unique keys with values, kept in a chain of cells.
// ----------------------------------------------------------------------------
// Each request passes through the states S_IDLE, S_CMP and S_RES. The edge
// that leaves S_IDLE accepts the transaction; in S_CMP every cell compares its
// key with the request key, and in S_RES the boundary position is encoded, the
// result is formed and the chain shifts as the result enters the output
// register. The next request is taken only once the block is back in S_IDLE,
// so no request is accepted before the previous one completes; it may be
// taken while the previous result still waits in the output register. A
// result that is not taken holds the block in S_RES until the output register
// frees up. Insert, remove, lookup and lower bound all follow this path
// whatever the fill level.
// Entries at or above the fill count hold stale data and are never reported.
// The capacity limit (cfg_wdata on cfg_we) should only change while idle.
// ----------------------------------------------------------------------------
module sorted_key_value_leaf_table #(
  parameter int CAPACITY   = skvlt_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = skvlt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = skvlt_pkg::VALUE_BITS_DEF,
  localparam int IN_W      = KEY_BITS + VALUE_BITS + skvlt_pkg::POS_IN_W,
  localparam int IN_TD_W   = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W     = KEY_BITS + VALUE_BITS + skvlt_pkg::POS_OUT_W
                             + skvlt_pkg::COUNT_W,
  localparam int OUT_TD_W  = ((OUT_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration: capacity limit in use
  input  logic                           cfg_we,
  input  logic [skvlt_pkg::CFG_W-1:0]    cfg_wdata,
  // request stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // low to high: search_key, entry_value, position_in, zero pad
  input  logic [IN_TD_W-1:0]             s_tdata,
  // action
  input  logic [skvlt_pkg::ACTION_W-1:0] s_tuser,
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // low to high: found_key, found_value, position_out, entry_count, zero pad
  output logic [OUT_TD_W-1:0]            m_tdata,
  // status
  output logic [skvlt_pkg::STATUS_W-1:0] m_tuser
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int POS_W = $clog2(CAPACITY + 1);
  localparam int LIM_W = (POS_W > skvlt_pkg::CFG_W) ? POS_W : skvlt_pkg::CFG_W;
  localparam int SEL_W = (IDX_W > skvlt_pkg::POS_IN_W) ? IDX_W : skvlt_pkg::POS_IN_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_RES  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // latched request
  logic [skvlt_pkg::ACTION_W-1:0] req_action;
  logic [KEY_BITS-1:0]            req_key;
  logic [VALUE_BITS-1:0]          req_value;
  logic [skvlt_pkg::POS_IN_W-1:0] req_pos;

  logic [POS_W-1:0]               count;
  logic [POS_W-1:0]               count_next;
  logic [skvlt_pkg::CFG_W-1:0]    max_entries;

  // chain signals
  skvlt_pkg::cell_ctrl_t [CAPACITY-1:0]   ctrl;
  skvlt_pkg::cell_flag_t [CAPACITY-1:0]   flag;
  logic [CAPACITY-1:0][KEY_BITS-1:0]      cell_key;
  logic [CAPACITY-1:0][VALUE_BITS-1:0]    cell_value;
  logic [CAPACITY-1:0]                    lt;
  logic [CAPACITY-1:0]                    eq;
  logic [CAPACITY-1:0]                    lt_below;
  logic [CAPACITY-1:0]                    bnd;
  logic [CAPACITY-1:0]                    rd_sel;
  logic [CAPACITY-1:0]                    data_sel;

  logic [IDX_W-1:0]               bnd_idx;
  logic                           bnd_any;
  logic [KEY_BITS-1:0]            pick_key;
  logic [VALUE_BITS-1:0]          pick_value;
  logic [POS_W-1:0]               lb_pos;
  logic                           hit;
  logic                           full;
  logic                           rd_ok;

  // result of the request in S_RES
  logic [skvlt_pkg::STATUS_W-1:0]  res_status;
  logic [KEY_BITS-1:0]             res_key;
  logic [VALUE_BITS-1:0]           res_value;
  logic [skvlt_pkg::POS_OUT_W-1:0] res_pos;
  logic                            do_insert;
  logic                            do_remove;
  logic                            commit;

  assign s_tready = (state == S_IDLE);
  assign commit   = (state == S_RES) && (!m_tvalid || m_tready);

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_CMP;
      end
      S_CMP: begin
        state_next = S_RES;
      end
      S_RES: begin
        if (commit) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      max_entries <= skvlt_pkg::MAX_ENTRIES_RST;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) max_entries <= cfg_wdata;
      if (commit) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_action <= s_tuser;
      req_key    <= s_tdata[KEY_BITS-1:0];
      req_value  <= s_tdata[KEY_BITS +: VALUE_BITS];
      req_pos    <= s_tdata[KEY_BITS+VALUE_BITS +: skvlt_pkg::POS_IN_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (commit) begin
      m_tuser <= res_status;
      m_tdata <= OUT_TD_W'({9'(count_next), res_pos, res_value, res_key});
    end
  end

  // --------------------------------------------------------------------------
  // cell chain
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_BITS-1:0]   prev_key;
    logic [VALUE_BITS-1:0] prev_value;
    logic [KEY_BITS-1:0]   next_key;
    logic [VALUE_BITS-1:0] next_value;

    // the ends of the chain feed back their own entry
    if (g == 0) begin : g_first
      assign prev_key   = cell_key[g];
      assign prev_value = cell_value[g];
    end else begin : g_mid_lo
      assign prev_key   = cell_key[g-1];
      assign prev_value = cell_value[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_key   = cell_key[g];
      assign next_value = cell_value[g];
    end else begin : g_mid_hi
      assign next_key   = cell_key[g+1];
      assign next_value = cell_value[g+1];
    end

    skvlt_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl[g]),
      .req_key    (req_key),
      .req_value  (req_value),
      .prev_key   (prev_key),
      .prev_value (prev_value),
      .next_key   (next_key),
      .next_value (next_value),
      .key        (cell_key[g]),
      .value      (cell_value[g]),
      .flag       (flag[g])
    );

    assign lt[g] = flag[g].lt;
    assign eq[g] = flag[g].eq;
  end

  // boundary: first live cell whose key is not below the request key,
  // or the first free cell when every live key is below
  assign lt_below = {lt[CAPACITY-2:0], 1'b1};
  assign bnd      = ~lt & lt_below;
  assign hit      = |(bnd & eq);
  assign data_sel = (req_action == skvlt_pkg::ACT_READ) ? rd_sel : (bnd & eq);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel[i] = (SEL_W'(req_pos) == SEL_W'(i));
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i].cmp_en = (state == S_CMP);
      ctrl[i].live   = (LIM_W'(i) < LIM_W'(count));
      ctrl[i].op     = skvlt_pkg::CELL_HOLD;
      if (do_insert && !lt[i]) begin
        ctrl[i].op = lt_below[i] ? skvlt_pkg::CELL_LOAD : skvlt_pkg::CELL_SHIFT_UP;
      end else if (do_remove && !lt[i]) begin
        ctrl[i].op = skvlt_pkg::CELL_SHIFT_DOWN;
      end
    end
  end

  skvlt_pick #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_pick (
    .bnd        (bnd),
    .data_sel   (data_sel),
    .keys       (cell_key),
    .values     (cell_value),
    .bnd_idx    (bnd_idx),
    .bnd_any    (bnd_any),
    .pick_key   (pick_key),
    .pick_value (pick_value)
  );

  // --------------------------------------------------------------------------
  // result
  // --------------------------------------------------------------------------
  assign lb_pos = bnd_any ? POS_W'(bnd_idx) : POS_W'(CAPACITY);
  // limit in use is max_entries saturated at capacity
  assign full   = (LIM_W'(count) >= LIM_W'(max_entries)) || (count >= POS_W'(CAPACITY));
  assign rd_ok  = (LIM_W'(req_pos) < LIM_W'(count));

  always_comb begin
    res_status = skvlt_pkg::ST_OK;
    res_key    = '0;
    res_value  = '0;
    res_pos    = '0;
    count_next = count;
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    unique case (req_action)
      skvlt_pkg::ACT_INSERT: begin
        res_pos = 9'(lb_pos);
        if (hit) begin
          res_status = skvlt_pkg::ST_DUPLICATE;
        end else if (full) begin
          res_status = skvlt_pkg::ST_FULL;
        end else begin
          do_insert  = commit;
          count_next = count + POS_W'(1);
        end
      end
      skvlt_pkg::ACT_LOOKUP: begin
        res_pos = 9'(lb_pos);
        if (hit) res_value = pick_value;
        else res_status = skvlt_pkg::ST_NOT_FOUND;
      end
      skvlt_pkg::ACT_REMOVE: begin
        res_pos = 9'(lb_pos);
        if (hit) begin
          do_remove  = commit;
          count_next = count - POS_W'(1);
        end else begin
          res_status = skvlt_pkg::ST_NOT_FOUND;
        end
      end
      skvlt_pkg::ACT_LOWER: begin
        res_pos = 9'(lb_pos);
      end
      skvlt_pkg::ACT_READ: begin
        if (rd_ok) begin
          res_key   = pick_key;
          res_value = pick_value;
          res_pos   = 9'(req_pos);
        end else begin
          res_status = skvlt_pkg::ST_RANGE;
        end
      end
      skvlt_pkg::ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  // fill level never passes the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= POS_W'(CAPACITY))
    else $error("fill count above capacity");

  // at most one boundary cell while a result is formed
  a_bnd_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == S_RES) |-> $onehot0(bnd))
    else $error("more than one boundary cell");

  // the fill count moves only when a request completes
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!commit && !rst) |=> $stable(count))
    else $error("fill count changed outside a commit");

  // the chain shifts only on a completing insert or remove
  a_shift_gate: assert property (@(posedge clk) disable iff (rst)
    (do_insert || do_remove) |-> (commit && hit == do_remove))
    else $error("chain shift without a valid commit");
`endif

endmodule

// ----- rtl/core/skvlt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvlt_cell
// One table slot: holds a key/value pair, compares it with the request key
// and takes a new pair or a neighbor's pair when the table shifts.
// ----------------------------------------------------------------------------
module skvlt_cell #(
  parameter int KEY_BITS   = skvlt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = skvlt_pkg::VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  skvlt_pkg::cell_ctrl_t  ctrl,
  input  logic [KEY_BITS-1:0]    req_key,
  input  logic [VALUE_BITS-1:0]  req_value,
  input  logic [KEY_BITS-1:0]    prev_key,
  input  logic [VALUE_BITS-1:0]  prev_value,
  input  logic [KEY_BITS-1:0]    next_key,
  input  logic [VALUE_BITS-1:0]  next_value,
  output logic [KEY_BITS-1:0]    key,
  output logic [VALUE_BITS-1:0]  value,
  output skvlt_pkg::cell_flag_t  flag
);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      skvlt_pkg::CELL_HOLD: begin
      end
      skvlt_pkg::CELL_LOAD: begin
        key   <= req_key;
        value <= req_value;
      end
      skvlt_pkg::CELL_SHIFT_UP: begin
        key   <= prev_key;
        value <= prev_value;
      end
      skvlt_pkg::CELL_SHIFT_DOWN: begin
        key   <= next_key;
        value <= next_value;
      end
      default: begin
      end
    endcase
    if (ctrl.cmp_en) begin
      flag.lt <= ctrl.live && (key < req_key);
      flag.eq <= ctrl.live && (key == req_key);
    end
  end

endmodule

// ----- rtl/core/skvlt_pick.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvlt_pick
// Encodes the boundary one-hot into a position and muxes out the selected
// cell's pair.
// ----------------------------------------------------------------------------
module skvlt_pick #(
  parameter int CAPACITY   = skvlt_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = skvlt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = skvlt_pkg::VALUE_BITS_DEF,
  localparam int IDX_W     = $clog2(CAPACITY)
) (
  input  logic [CAPACITY-1:0]                 bnd,
  input  logic [CAPACITY-1:0]                 data_sel,
  input  logic [CAPACITY-1:0][KEY_BITS-1:0]   keys,
  input  logic [CAPACITY-1:0][VALUE_BITS-1:0] values,
  output logic [IDX_W-1:0]                    bnd_idx,
  output logic                                bnd_any,
  output logic [KEY_BITS-1:0]                 pick_key,
  output logic [VALUE_BITS-1:0]               pick_value
);

  // both selects are one-hot or empty, so plain and-or trees suffice
  always_comb begin
    bnd_idx    = '0;
    bnd_any    = 1'b0;
    pick_key   = '0;
    pick_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      bnd_idx    = bnd_idx | ({IDX_W{bnd[i]}} & IDX_W'(i));
      bnd_any    = bnd_any | bnd[i];
      pick_key   = pick_key | ({KEY_BITS{data_sel[i]}} & keys[i]);
      pick_value = pick_value | ({VALUE_BITS{data_sel[i]}} & values[i]);
    end
  end

endmodule
